/* rtl/rbf_pkg.sv */
// Shared types and codes for the batched ring FIFO.
// No dependencies; used by the sequencer and the top level.
package rbf_pkg;

  // widths fixed by the register map and the beat fields
  localparam int unsigned CAP_W        = 5;
  localparam int unsigned EB_W         = 4;
  localparam int unsigned CFG_DATA_W   = 5;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned MODE_W       = 2;
  localparam int unsigned COUNT_W      = 16;
  localparam int unsigned ELEM_PORT_W  = 64;
  localparam int unsigned ACT_W        = 5;
  localparam int unsigned MAX_OUT      = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_BYTES = 1'd1;

  // reset values of the registers
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [EB_W-1:0]  EB_RESET  = 4'd8;

  // operation codes carried by the mode field
  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLOSE = 2'd2
  } mode_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_OUT_OF_RANGE = 2'd1,
    ST_SHOULD_WAIT  = 2'd2,
    ST_PEER_CLOSED  = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ_CHK,
    S_READ_REQ,
    S_READ_OUT,
    S_RESULT
  } state_e;

  // one result beat handed from the sequencer to the output register
  typedef struct packed {
    status_e                  status;
    logic [ELEM_PORT_W-1:0]   element;
    logic [ACT_W-1:0]         count;
    logic                     last;
    logic                     readable;
    logic                     writable;
    logic                     peer_gone;
  } res_t;

endpackage

/* rtl/rbf_slot_mem.sv */
// Element slot storage: one write port, one read port with registered data.
// No package dependencies.
module rbf_slot_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rbf_seq.sv */
// Sequencer of the batched ring FIFO: registers, ring indices, batch state,
// and one step per cycle over the slot memory unless the result side stalls. Uses rbf_pkg.
module rbf_seq #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned ELEM_BITS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // register writes
  input  logic                              cfg_we_i,
  input  logic [rbf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rbf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input beat
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [rbf_pkg::MODE_W-1:0]        mode_i,
  input  logic [rbf_pkg::EB_W-1:0]          claimed_size_i,
  input  logic [rbf_pkg::ELEM_PORT_W-1:0]   element_in_i,
  input  logic                              last_in_batch_i,
  input  logic [rbf_pkg::COUNT_W-1:0]       request_count_i,
  // result beat
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output rbf_pkg::res_t                     res_o,
  // slot memory
  output logic                              mem_we_o,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] mem_waddr_o,
  output logic [ELEM_BITS-1:0]              mem_wdata_o,
  output logic                              mem_re_o,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] mem_raddr_o,
  input  logic [ELEM_BITS-1:0]              mem_rdata_i
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OW = $clog2(DEPTH + 1);
  localparam int unsigned AW = rbf_pkg::ACT_W;

  rbf_pkg::state_e state_q, state_d;

  // configuration
  logic [rbf_pkg::CAP_W-1:0] capacity_q, capacity_d;
  logic [rbf_pkg::EB_W-1:0]  elem_bytes_q, elem_bytes_d;

  // ring and batch state
  logic [IW-1:0] wi_q, wi_d, ri_q, ri_d;
  logic [OW-1:0] occ_q, occ_d;
  logic [OW-1:0] bacc_q, bacc_d;
  logic [OW-1:0] broom_q, broom_d;
  logic          bopen_q, bopen_d;
  logic          peer_q, peer_d;

  // latched item
  logic [rbf_pkg::EB_W-1:0]        claimed_q;
  logic [rbf_pkg::ELEM_PORT_W-1:0] data_q;
  logic                            last_q;
  logic [rbf_pkg::COUNT_W-1:0]     count_q;

  // pending result and read burst bookkeeping
  rbf_pkg::status_e res_status_q, res_status_d;
  logic [AW-1:0]    res_count_q, res_count_d;
  logic [AW-1:0]    rd_n_q, rd_n_d;
  logic [AW-1:0]    rd_left_q, rd_left_d;
  logic             rd_readable_q, rd_readable_d;
  logic             rd_writable_q, rd_writable_d;

  logic             in_fire;
  logic [OW-1:0]    cap;
  logic [ELEM_BITS-1:0] mask;
  logic [3:0]       eb_clamped;
  logic [6:0]       mask_bits;

  // write step terms
  logic [OW-1:0]    j_acc, j_room, w_acc, w_room, w_acc2;
  logic             w_take;

  // read check terms
  logic             rd_bad;
  logic [rbf_pkg::COUNT_W-1:0] occ_wide, n_full;
  logic [AW-1:0]    rd_n;
  logic [OW-1:0]    occ_after;

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i, input logic [OW-1:0] c);
    logic [OW-1:0] inc;
    inc = OW'(i) + OW'(1);
    return (inc >= c) ? '0 : (i + IW'(1));
  endfunction

  assign in_ready_o = (state_q == rbf_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // slots in use, clamped to 1..DEPTH
  always_comb begin
    if (capacity_q == '0) begin
      cap = OW'(1);
    end else if (int'(capacity_q) > DEPTH) begin
      cap = OW'(DEPTH);
    end else begin
      cap = OW'(capacity_q);
    end
  end

  // element mask from the configured byte count
  always_comb begin
    eb_clamped = (elem_bytes_q > 4'd8) ? 4'd8 : elem_bytes_q;
    mask_bits  = {eb_clamped, 3'b000};
    for (int k = 0; k < ELEM_BITS; k++) begin
      mask[k] = (k < int'(mask_bits));
    end
  end

  // batch judgment and accept decision for one write element
  always_comb begin
    j_acc  = '0;
    j_room = '0;
    if (peer_q) begin
      j_acc = OW'(rbf_pkg::ST_PEER_CLOSED);
    end else if (claimed_q != elem_bytes_q) begin
      j_acc = OW'(rbf_pkg::ST_OUT_OF_RANGE);
    end else begin
      j_room = (occ_q >= cap) ? '0 : (cap - occ_q);
      if (j_room == '0) begin
        j_acc = OW'(rbf_pkg::ST_SHOULD_WAIT);
      end
    end
    w_acc  = bopen_q ? bacc_q : j_acc;
    w_room = bopen_q ? broom_q : j_room;
    w_take = (w_room != '0) && (w_acc < w_room) && (occ_q < cap);
    w_acc2 = w_acc + OW'(w_take);
  end

  // read request check and burst length
  always_comb begin
    rd_bad    = (claimed_q != elem_bytes_q) || (count_q == '0);
    occ_wide  = rbf_pkg::COUNT_W'(occ_q);
    n_full    = (count_q < occ_wide) ? count_q : occ_wide;
    rd_n      = (n_full > rbf_pkg::COUNT_W'(rbf_pkg::MAX_OUT)) ?
                AW'(rbf_pkg::MAX_OUT) : AW'(n_full);
    occ_after = occ_q - OW'(rd_n);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rbf_pkg::S_IDLE: begin
        if (in_fire) begin
          case (mode_i)
            rbf_pkg::MODE_WRITE: state_d = rbf_pkg::S_WRITE;
            rbf_pkg::MODE_READ:  state_d = rbf_pkg::S_READ_CHK;
            rbf_pkg::MODE_CLOSE: state_d = rbf_pkg::S_RESULT;
            default:             state_d = rbf_pkg::S_IDLE;
          endcase
        end
      end
      rbf_pkg::S_WRITE: begin
        state_d = last_q ? rbf_pkg::S_RESULT : rbf_pkg::S_IDLE;
      end
      rbf_pkg::S_READ_CHK: begin
        state_d = (rd_bad || (occ_q == '0)) ? rbf_pkg::S_RESULT : rbf_pkg::S_READ_REQ;
      end
      rbf_pkg::S_READ_REQ: begin
        state_d = rbf_pkg::S_READ_OUT;
      end
      rbf_pkg::S_READ_OUT: begin
        if (res_ready_i) begin
          state_d = (rd_left_q == AW'(1)) ? rbf_pkg::S_IDLE : rbf_pkg::S_READ_REQ;
        end
      end
      rbf_pkg::S_RESULT: begin
        if (res_ready_i) begin
          state_d = rbf_pkg::S_IDLE;
        end
      end
      default: state_d = rbf_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    capacity_d    = capacity_q;
    elem_bytes_d  = elem_bytes_q;
    wi_d          = wi_q;
    ri_d          = ri_q;
    occ_d         = occ_q;
    bacc_d        = bacc_q;
    broom_d       = broom_q;
    bopen_d       = bopen_q;
    peer_d        = peer_q;
    res_status_d  = res_status_q;
    res_count_d   = res_count_q;
    rd_n_d        = rd_n_q;
    rd_left_d     = rd_left_q;
    rd_readable_d = rd_readable_q;
    rd_writable_d = rd_writable_q;
    mem_we_o      = 1'b0;
    mem_re_o      = 1'b0;
    mem_waddr_o   = wi_q;
    mem_raddr_o   = ri_q;
    mem_wdata_o   = data_q[ELEM_BITS-1:0] & mask;
    res_valid_o   = 1'b0;
    res_o.status    = res_status_q;
    res_o.element   = '0;
    res_o.count     = res_count_q;
    res_o.last      = 1'b1;
    res_o.readable  = (occ_q != '0);
    res_o.writable  = (occ_q < cap) && !peer_q;
    res_o.peer_gone = peer_q;

    case (state_q)
      rbf_pkg::S_IDLE: begin
        // a close event is settled at once
        if (in_fire && (mode_i == rbf_pkg::MODE_CLOSE)) begin
          peer_d       = 1'b1;
          res_status_d = rbf_pkg::ST_OK;
          res_count_d  = '0;
        end
      end
      rbf_pkg::S_WRITE: begin
        if (w_take) begin
          mem_we_o = 1'b1;
          wi_d     = next_idx(wi_q, cap);
          occ_d    = occ_q + OW'(1);
        end
        if (last_q) begin
          bopen_d = 1'b0;
          bacc_d  = '0;
          broom_d = '0;
          if (w_room == '0) begin
            res_status_d = rbf_pkg::status_e'(w_acc2[1:0]);
            res_count_d  = '0;
          end else begin
            res_status_d = rbf_pkg::ST_OK;
            res_count_d  = AW'(w_acc2);
          end
        end else begin
          bopen_d = 1'b1;
          bacc_d  = w_acc2;
          broom_d = w_room;
        end
      end
      rbf_pkg::S_READ_CHK: begin
        res_count_d = '0;
        if (rd_bad) begin
          res_status_d = rbf_pkg::ST_OUT_OF_RANGE;
        end else if (occ_q == '0) begin
          res_status_d = peer_q ? rbf_pkg::ST_PEER_CLOSED : rbf_pkg::ST_SHOULD_WAIT;
        end else begin
          // flags reflect the state after the whole burst
          rd_n_d        = rd_n;
          rd_left_d     = rd_n;
          rd_readable_d = (occ_after != '0);
          rd_writable_d = (occ_after < cap) && !peer_q;
        end
      end
      rbf_pkg::S_READ_REQ: begin
        mem_re_o = 1'b1;
      end
      rbf_pkg::S_READ_OUT: begin
        res_valid_o    = 1'b1;
        res_o.status   = rbf_pkg::ST_OK;
        res_o.element  = rbf_pkg::ELEM_PORT_W'(mem_rdata_i);
        res_o.count    = rd_n_q;
        res_o.last     = (rd_left_q == AW'(1));
        res_o.readable = rd_readable_q;
        res_o.writable = rd_writable_q;
        if (res_ready_i) begin
          ri_d      = next_idx(ri_q, cap);
          occ_d     = occ_q - OW'(1);
          rd_left_d = rd_left_q - AW'(1);
        end
      end
      rbf_pkg::S_RESULT: begin
        res_valid_o = 1'b1;
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase

    // register writes; a capacity write empties the ring
    if (cfg_we_i) begin
      case (cfg_index_i)
        rbf_pkg::CFG_CAPACITY: begin
          capacity_d = cfg_data_i[rbf_pkg::CAP_W-1:0];
          wi_d       = '0;
          ri_d       = '0;
          occ_d      = '0;
          bacc_d     = '0;
          broom_d    = '0;
          bopen_d    = 1'b0;
        end
        rbf_pkg::CFG_ELEM_BYTES: begin
          elem_bytes_d = cfg_data_i[rbf_pkg::EB_W-1:0];
        end
        default: begin
          elem_bytes_d = elem_bytes_q;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= rbf_pkg::S_IDLE;
      capacity_q    <= rbf_pkg::CAP_RESET;
      elem_bytes_q  <= rbf_pkg::EB_RESET;
      wi_q          <= '0;
      ri_q          <= '0;
      occ_q         <= '0;
      bacc_q        <= '0;
      broom_q       <= '0;
      bopen_q       <= 1'b0;
      peer_q        <= 1'b0;
      res_status_q  <= rbf_pkg::ST_OK;
      res_count_q   <= '0;
      rd_n_q        <= '0;
      rd_left_q     <= '0;
      rd_readable_q <= 1'b0;
      rd_writable_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      capacity_q    <= capacity_d;
      elem_bytes_q  <= elem_bytes_d;
      wi_q          <= wi_d;
      ri_q          <= ri_d;
      occ_q         <= occ_d;
      bacc_q        <= bacc_d;
      broom_q       <= broom_d;
      bopen_q       <= bopen_d;
      peer_q        <= peer_d;
      res_status_q  <= res_status_d;
      res_count_q   <= res_count_d;
      rd_n_q        <= rd_n_d;
      rd_left_q     <= rd_left_d;
      rd_readable_q <= rd_readable_d;
      rd_writable_q <= rd_writable_d;
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      claimed_q <= claimed_size_i;
      data_q    <= element_in_i;
      last_q    <= last_in_batch_i;
      count_q   <= request_count_i;
    end
  end

endmodule

/* rtl/batched_ring_fifo_with_signals.sv */
// Top level of the batched ring FIFO: sequencer, slot memory, result register.
// Depends on rbf_pkg, rbf_seq and rbf_slot_mem.
//
// Usage:
//  - input channel (in_valid_i / in_stall_o) carries one operation per beat:
//    a write element (batches close with last_in_batch_i), a read request or
//    a peer-closed event; mode 3 is dropped without a result
//  - output channel (out_valid_o / out_stall_i) carries result beats; a read
//    gives one beat per element, everything else at most one beat
//  - register port (cfg_we_i, cfg_index_i, cfg_data_i) sets capacity and
//    element size; a capacity write empties the ring; write only when idle
//  - steps: a write element holds the input through the write state, and
//    also the result state when it closes a batch; a read has a check, then
//    one memory read and one hand-off per element through the single-port
//    read of the slot memory; every result beat passes the result register
//  - when the receiver stalls, the sequencer waits with its next beat and the
//    input stays stalled until the operation has handed off all its results
//  - reset empties the ring, clears the peer-closed flag and restores
//    capacity 16 and element size 8; slot contents are left as they are
module batched_ring_fifo_with_signals #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned ELEM_BITS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // register port
  input  logic                             cfg_we_i,
  input  logic [rbf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rbf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [rbf_pkg::MODE_W-1:0]       mode_i,
  input  logic [rbf_pkg::EB_W-1:0]         claimed_size_i,
  input  logic [rbf_pkg::ELEM_PORT_W-1:0]  element_in_i,
  input  logic                             last_in_batch_i,
  input  logic [rbf_pkg::COUNT_W-1:0]      request_count_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic [rbf_pkg::ELEM_PORT_W-1:0]  element_out_o,
  output logic [rbf_pkg::ACT_W-1:0]        actual_count_o,
  output logic                             last_result_o,
  output logic                             readable_o,
  output logic                             writable_o,
  output logic                             peer_gone_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                 in_ready;
  logic                 res_valid, res_ready;
  rbf_pkg::res_t        res;
  logic                 mem_we, mem_re;
  logic [IW-1:0]        mem_waddr, mem_raddr;
  logic [ELEM_BITS-1:0] mem_wdata, mem_rdata;

  logic                 out_valid_q, out_valid_d;
  rbf_pkg::res_t        out_q;

  rbf_seq #(
    .DEPTH     (DEPTH),
    .ELEM_BITS (ELEM_BITS)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready),
    .mode_i          (mode_i),
    .claimed_size_i  (claimed_size_i),
    .element_in_i    (element_in_i),
    .last_in_batch_i (last_in_batch_i),
    .request_count_i (request_count_i),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata)
  );

  rbf_slot_mem #(
    .DEPTH (DEPTH),
    .WIDTH (ELEM_BITS),
    .AW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_stall_o = !in_ready;

  // result register: refills whenever empty or its beat is taken
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign element_out_o  = out_q.element;
  assign actual_count_o = out_q.count;
  assign last_result_o  = out_q.last;
  assign readable_o     = out_q.readable;
  assign writable_o     = out_q.writable;
  assign peer_gone_o    = out_q.peer_gone;

  // element data only ever rides on a successful read beat
  a_elem_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (element_out_o != '0) |-> (status_o == rbf_pkg::ST_OK))
    else $error("element data on a non-ok result");

  // a gone peer never leaves the ring writable
  a_closed_not_writable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(writable_o && peer_gone_o))
    else $error("writable reported after peer closed");

  // no operation moves more elements than one burst allows
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (actual_count_o <= 5'd16))
    else $error("actual count above burst limit");

  // the input stays stalled while a result is still being produced
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> in_stall_o)
    else $error("input taken while a result is pending");

endmodule

/* test/testbench.sv */
// Self-checking bench for the batched ring FIFO: directed script and random traffic, in turn.
// Expected beats come from a predictor kept inside this file.
// Depends on rbf_pkg and batched_ring_fifo_with_signals.
module testbench;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned PRINT_LIMIT   = 40;
  localparam int unsigned SLOTS         = 16;

  // the mode code the block drops without a result
  localparam logic [rbf_pkg::MODE_W-1:0] MODE_NONE = 2'd3;

  typedef struct packed {
    rbf_pkg::status_e                status;
    logic [rbf_pkg::ELEM_PORT_W-1:0] element;
    logic [rbf_pkg::ACT_W-1:0]       count;
    logic                            last;
    logic                            readable;
    logic                            writable;
    logic                            gone;
  } fifo_beat_t;

  typedef enum logic [1:0] {ROW_OP, ROW_CHECK, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e                       kind;
    logic [rbf_pkg::CFG_IDX_W-1:0]   reg_idx;
    logic [rbf_pkg::CFG_DATA_W-1:0]  reg_val;
    logic [rbf_pkg::MODE_W-1:0]      mode;
    logic [rbf_pkg::EB_W-1:0]        csize;
    logic [rbf_pkg::ELEM_PORT_W-1:0] data;
    logic                            last;
    logic [rbf_pkg::COUNT_W-1:0]     count;
    rbf_pkg::status_e                st;
    logic [rbf_pkg::ACT_W-1:0]       cnt;
    logic                            rd;
    logic                            wr;
    logic                            gone;
  } script_row_t;

  // drive side
  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [rbf_pkg::CFG_IDX_W-1:0]   cfg_index = rbf_pkg::CFG_CAPACITY;
  logic [rbf_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic [rbf_pkg::MODE_W-1:0]      op_mode = rbf_pkg::MODE_WRITE;
  logic [rbf_pkg::EB_W-1:0]        op_size = '0;
  logic [rbf_pkg::ELEM_PORT_W-1:0] op_data = '0;
  logic                            op_last = 1'b0;
  logic [rbf_pkg::COUNT_W-1:0]     op_count = '0;
  logic                            out_stall = 1'b0;

  // observe side
  logic                            in_stall_o;
  logic                            out_valid_o;
  logic [1:0]                      status_o;
  logic [rbf_pkg::ELEM_PORT_W-1:0] element_out_o;
  logic [rbf_pkg::ACT_W-1:0]       actual_count_o;
  logic                            last_result_o;
  logic                            readable_o;
  logic                            writable_o;
  logic                            peer_gone_o;

  // predictor state
  logic [rbf_pkg::ELEM_PORT_W-1:0] ring_mem [SLOTS];
  logic [3:0]                      wr_ptr;
  logic [3:0]                      rd_ptr;
  logic [4:0]                      fill_level;
  logic [4:0]                      batch_taken;
  logic [4:0]                      batch_space;
  logic                            batch_live;
  logic                            writer_closed;
  logic [rbf_pkg::CAP_W-1:0]       capacity_q;
  logic [rbf_pkg::EB_W-1:0]        elem_bytes_q;

  fifo_beat_t  results_due [$];
  fifo_beat_t  oldest;
  script_row_t script [$];
  int          close_from;
  int          mismatches = 0;
  int          send_gap_pct = 0;
  int          stall_pct = 0;
  int          hold_pending = 0;

  batched_ring_fifo_with_signals uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .mode_i          (op_mode),
    .claimed_size_i  (op_size),
    .element_in_i    (op_data),
    .last_in_batch_i (op_last),
    .request_count_i (op_count),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .status_o        (status_o),
    .element_out_o   (element_out_o),
    .actual_count_o  (actual_count_o),
    .last_result_o   (last_result_o),
    .readable_o      (readable_o),
    .writable_o      (writable_o),
    .peer_gone_o     (peer_gone_o)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // slots in use, with zero read as one and oversize clipped to the ring
  function automatic logic [4:0] slot_limit();
    if (capacity_q == 0) return 5'd1;
    if (capacity_q > SLOTS) return 5'(SLOTS);
    return capacity_q;
  endfunction

  function automatic logic [3:0] ring_next(logic [3:0] idx);
    return (idx + 1 >= slot_limit()) ? 4'd0 : 4'(idx + 1);
  endfunction

  // low element_bytes bytes of a written element are kept
  function automatic logic [rbf_pkg::ELEM_PORT_W-1:0] byte_mask();
    int unsigned bits;
    bits = ((elem_bytes_q > 8) ? 8 : elem_bytes_q) * 8;
    return (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
  endfunction

  function automatic void clear_ring();
    wr_ptr      = '0;
    rd_ptr      = '0;
    fill_level  = '0;
    batch_taken = '0;
    batch_space = '0;
    batch_live  = 1'b0;
  endfunction

  function automatic void apply_reg(logic [rbf_pkg::CFG_IDX_W-1:0] idx,
                                    logic [rbf_pkg::CFG_DATA_W-1:0] val);
    if (idx == rbf_pkg::CFG_CAPACITY) begin
      capacity_q = val;
      clear_ring();
    end else begin
      elem_bytes_q = val[rbf_pkg::EB_W-1:0];
    end
  endfunction

  // status signals are taken after the operation
  function automatic fifo_beat_t flagged(rbf_pkg::status_e st,
                                         logic [rbf_pkg::ELEM_PORT_W-1:0] el,
                                         logic [rbf_pkg::ACT_W-1:0] cnt, logic fin);
    fifo_beat_t r;
    r.status   = st;
    r.element  = el;
    r.count    = cnt;
    r.last     = fin;
    r.readable = fill_level != 0;
    r.writable = (fill_level < slot_limit()) && !writer_closed;
    r.gone     = writer_closed;
    return r;
  endfunction

  function automatic void predict_fifo_beat(logic [rbf_pkg::MODE_W-1:0] mode,
                                            logic [rbf_pkg::EB_W-1:0] cs,
                                            logic [rbf_pkg::ELEM_PORT_W-1:0] data, logic fin,
                                            logic [rbf_pkg::COUNT_W-1:0] cnt);
    logic [rbf_pkg::ELEM_PORT_W-1:0] picked [rbf_pkg::MAX_OUT];
    int unsigned n;
    logic [4:0] lim;
    lim = slot_limit();
    case (mode)
      rbf_pkg::MODE_WRITE: begin
        // a batch is judged once, on its first element
        if (!batch_live) begin
          batch_live  = 1'b1;
          batch_taken = '0;
          batch_space = '0;
          if (writer_closed) begin
            batch_taken = 5'(rbf_pkg::ST_PEER_CLOSED);
          end else if (cs != elem_bytes_q) begin
            batch_taken = 5'(rbf_pkg::ST_OUT_OF_RANGE);
          end else begin
            batch_space = (fill_level >= lim) ? 5'd0 : 5'(lim - fill_level);
            if (batch_space == 0) batch_taken = 5'(rbf_pkg::ST_SHOULD_WAIT);
          end
        end
        if (batch_space != 0 && batch_taken < batch_space && fill_level < lim) begin
          ring_mem[wr_ptr] = data & byte_mask();
          wr_ptr = ring_next(wr_ptr);
          fill_level++;
          batch_taken++;
        end
        if (fin) begin
          batch_live = 1'b0;
          if (batch_space == 0)
            results_due.push_back(flagged(rbf_pkg::status_e'(batch_taken[1:0]), '0, '0,
                                          1'b1));
          else
            results_due.push_back(flagged(rbf_pkg::ST_OK, '0, batch_taken, 1'b1));
          batch_taken = '0;
          batch_space = '0;
        end
      end
      rbf_pkg::MODE_READ: begin
        if (cs != elem_bytes_q || cnt == 0) begin
          results_due.push_back(flagged(rbf_pkg::ST_OUT_OF_RANGE, '0, '0, 1'b1));
        end else if (fill_level == 0) begin
          results_due.push_back(flagged(writer_closed ? rbf_pkg::ST_PEER_CLOSED :
                                        rbf_pkg::ST_SHOULD_WAIT, '0, '0, 1'b1));
        end else begin
          n = (cnt < 16'(fill_level)) ? 32'(cnt) : 32'(fill_level);
          if (n > rbf_pkg::MAX_OUT) n = rbf_pkg::MAX_OUT;
          for (int i = 0; i < n; i++) begin
            picked[i] = ring_mem[rd_ptr];
            rd_ptr = ring_next(rd_ptr);
            fill_level--;
          end
          for (int i = 0; i < n; i++)
            results_due.push_back(flagged(rbf_pkg::ST_OK, picked[i], 5'(n), i + 1 == n));
        end
      end
      rbf_pkg::MODE_CLOSE: begin
        writer_closed = 1'b1;
        results_due.push_back(flagged(rbf_pkg::ST_OK, '0, '0, 1'b1));
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic offer_beat(logic [rbf_pkg::MODE_W-1:0] mode, logic [rbf_pkg::EB_W-1:0] cs,
                            logic [rbf_pkg::ELEM_PORT_W-1:0] data, logic fin,
                            logic [rbf_pkg::COUNT_W-1:0] cnt);
    in_valid <= 1'b1;
    op_mode  <= mode;
    op_size  <= cs;
    op_data  <= data;
    op_last  <= fin;
    op_count <= cnt;
    do @(posedge clk); while (in_stall_o !== 1'b0);
    predict_fifo_beat(mode, cs, data, fin, cnt);
  endtask

  // random sender gap after an accepted beat
  task automatic maybe_pause();
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // block is idle once every beat is back and the last element has settled
  task automatic settle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [rbf_pkg::CFG_IDX_W-1:0] idx,
                           logic [rbf_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    apply_reg(idx, val);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_script(int first, int stop);
    fifo_beat_t typed;
    script_row_t r;
    for (int i = first; i < stop; i++) begin
      r = script[i];
      if (r.kind == ROW_REG) begin
        settle();
        write_reg(r.reg_idx, r.reg_val);
      end else begin
        offer_beat(r.mode, r.csize, r.data, r.last, r.count);
        // swap in the hand-written beat for rows whose answer is obvious
        if (r.kind == ROW_CHECK) begin
          typed.status   = r.st;
          typed.element  = '0;
          typed.count    = r.cnt;
          typed.last     = 1'b1;
          typed.readable = r.rd;
          typed.writable = r.wr;
          typed.gone     = r.gone;
          void'(results_due.pop_back());
          results_due.push_back(typed);
        end
        maybe_pause();
      end
    end
  endtask

  task automatic random_read(logic [4:0] lim);
    int sel;
    logic [rbf_pkg::EB_W-1:0] cs;
    logic [rbf_pkg::COUNT_W-1:0] cnt;
    sel = $urandom_range(99);
    cs  = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : elem_bytes_q;
    if (sel < 70)      cnt = 16'($urandom_range(lim + 1, 1));
    else if (sel < 85) cnt = '0;
    else               cnt = 16'($urandom);
    offer_beat(rbf_pkg::MODE_READ, cs, {$urandom, $urandom}, 1'($urandom), cnt);
    maybe_pause();
  endtask

  // mostly whole batches and sized reads, with some noise
  task automatic random_traffic(int target, bit with_close);
    int sent;
    int pick;
    int len;
    logic [4:0] lim;
    logic [rbf_pkg::EB_W-1:0] size;
    logic [rbf_pkg::EB_W-1:0] cs;
    sent = 0;
    while (sent < target) begin
      lim  = slot_limit();
      pick = $urandom_range(99);
      if (pick < 5) begin
        offer_beat(MODE_NONE, 4'($urandom), {$urandom, $urandom}, 1'($urandom),
                   16'($urandom));
        maybe_pause();
      end else if (with_close && pick < 12) begin
        offer_beat(rbf_pkg::MODE_CLOSE, 4'($urandom), {$urandom, $urandom}, 1'($urandom),
                   16'($urandom));
        maybe_pause();
        sent++;
      end else if (pick < 55) begin
        len  = $urandom_range(lim + 2, 1);
        size = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : elem_bytes_q;
        for (int k = 0; k < len; k++) begin
          // reads may slip in while a batch is open
          if (k > 0 && $urandom_range(9) == 0) begin
            random_read(lim);
            sent++;
          end
          cs = (k == 0 || $urandom_range(3) != 0) ? size : 4'($urandom_range(15));
          offer_beat(rbf_pkg::MODE_WRITE, cs, {$urandom, $urandom}, k == len - 1,
                     16'($urandom));
          maybe_pause();
          sent++;
        end
      end else begin
        random_read(lim);
        sent++;
      end
    end
  endtask

  task automatic run_phase(logic [rbf_pkg::CFG_DATA_W-1:0] cap,
                           logic [rbf_pkg::CFG_DATA_W-1:0] eb,
                           int gap, int stall, bit hold, int items);
    settle();
    write_reg(rbf_pkg::CFG_CAPACITY, cap);
    write_reg(rbf_pkg::CFG_ELEM_BYTES, eb);
    send_gap_pct = gap;
    stall_pct    = stall;
    if (hold) hold_pending++;
    random_traffic(items, 1'b0);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_LIMIT) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid_o === 1'b1 && !out_stall) begin
      if (results_due.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        oldest = results_due.pop_front();
        if (status_o !== oldest.status)
          report_mismatch($sformatf("status %0d, want %0d", status_o, oldest.status));
        if (element_out_o !== oldest.element)
          report_mismatch($sformatf("element %h, want %h", element_out_o, oldest.element));
        if (actual_count_o !== oldest.count)
          report_mismatch($sformatf("count %0d, want %0d", actual_count_o, oldest.count));
        if (last_result_o !== oldest.last)
          report_mismatch($sformatf("last %b, want %b", last_result_o, oldest.last));
        if (readable_o !== oldest.readable)
          report_mismatch($sformatf("readable %b, want %b", readable_o, oldest.readable));
        if (writable_o !== oldest.writable)
          report_mismatch($sformatf("writable %b, want %b", writable_o, oldest.writable));
        if (peer_gone_o !== oldest.gone)
          report_mismatch($sformatf("peer_gone %b, want %b", peer_gone_o, oldest.gone));
      end
    end
  end

  // receiver: random stall, plus a long hold-off on request
  initial begin
    int served;
    served = 0;
    forever begin
      @(posedge clk);
      if (hold_pending != served) begin
        served = hold_pending;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles with no beat moving on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("testbench: errors");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    // after reset: empty, bad reads, bad batch, dropped mode
    script.push_back('{ROW_CHECK, rbf_pkg::CFG_CAPACITY, 5'd0, rbf_pkg::MODE_READ, 4'd8,
                       64'd0, 1'b0, 16'd1, rbf_pkg::ST_SHOULD_WAIT, 5'd0, 1'b0, 1'b1, 1'b0});
    script.push_back('{ROW_CHECK, rbf_pkg::CFG_CAPACITY, 5'd0, rbf_pkg::MODE_READ, 4'd8,
                       64'd0, 1'b0, 16'd0, rbf_pkg::ST_OUT_OF_RANGE, 5'd0, 1'b0, 1'b1, 1'b0});
    script.push_back('{ROW_CHECK, rbf_pkg::CFG_CAPACITY, 5'd0, rbf_pkg::MODE_WRITE, 4'd5,
                       '1, 1'b1, 16'd0, rbf_pkg::ST_OUT_OF_RANGE, 5'd0, 1'b0, 1'b1, 1'b0});
    script.push_back('{ROW_OP, rbf_pkg::CFG_CAPACITY, 5'd0, MODE_NONE, 4'd8,
                       64'd7, 1'b1, 16'd1, rbf_pkg::ST_OK, 5'd0, 1'b0, 1'b0, 1'b0});
    // three-element batch, later sizes ignored, then an oversized read
    script.push_back('{ROW_OP, rbf_pkg::CFG_CAPACITY, 5'd0, rbf_pkg::MODE_WRITE, 4'd8,
                       '1, 1'b0, 16'd0, rbf_pkg::ST_OK, 5'd0, 1'b0, 1'b0, 1'b0});
    script.push_back('{ROW_OP, rbf_pkg::CFG_CAPACITY, 5'd0, rbf_pkg::MODE_WRITE, 4'd8,
                       64'd0, 1'b0, 16'd0, rbf_pkg::ST_OK, 5'd0, 1'b0, 1'b0, 1'b0});
    script.push_back('{ROW_CHECK, rbf_pkg::CFG_CAPACITY, 5'd0, rbf_pkg::MODE_WRITE, 4'd2,
                       64'hA5A5_5A5A_0F0F_F0F0, 1'b1, 16'd0,
                       rbf_pkg::ST_OK, 5'd3, 1'b1, 1'b1, 1'b0});
    script.push_back('{ROW_OP, rbf_pkg::CFG_CAPACITY, 5'd0, rbf_pkg::MODE_READ, 4'd8,
                       64'd0, 1'b0, 16'hFFFF, rbf_pkg::ST_OK, 5'd0, 1'b0, 1'b0, 1'b0});
    script.push_back('{ROW_CHECK, rbf_pkg::CFG_CAPACITY, 5'd0, rbf_pkg::MODE_READ, 4'd15,
                       64'd0, 1'b1, 16'd1, rbf_pkg::ST_OUT_OF_RANGE, 5'd0, 1'b0, 1'b1, 1'b0});
    // open batch dropped by a capacity write, then overflow at capacity one
    script.push_back('{ROW_OP, rbf_pkg::CFG_CAPACITY, 5'd0, rbf_pkg::MODE_WRITE, 4'd8,
                       64'h0123_4567_89AB_CDEF, 1'b0, 16'd0,
                       rbf_pkg::ST_OK, 5'd0, 1'b0, 1'b0, 1'b0});
    script.push_back('{ROW_REG, rbf_pkg::CFG_CAPACITY, 5'd1, rbf_pkg::MODE_WRITE, 4'd0,
                       64'd0, 1'b0, 16'd0, rbf_pkg::ST_OK, 5'd0, 1'b0, 1'b0, 1'b0});
    script.push_back('{ROW_OP, rbf_pkg::CFG_CAPACITY, 5'd0, rbf_pkg::MODE_WRITE, 4'd8,
                       64'h8000_0000_0000_0001, 1'b0, 16'd0,
                       rbf_pkg::ST_OK, 5'd0, 1'b0, 1'b0, 1'b0});
    script.push_back('{ROW_CHECK, rbf_pkg::CFG_CAPACITY, 5'd0, rbf_pkg::MODE_WRITE, 4'd8,
                       64'hDEAD_BEEF_0000_FFFF, 1'b1, 16'd0,
                       rbf_pkg::ST_OK, 5'd1, 1'b1, 1'b0, 1'b0});
    script.push_back('{ROW_CHECK, rbf_pkg::CFG_CAPACITY, 5'd0, rbf_pkg::MODE_WRITE, 4'd8,
                       64'd0, 1'b1, 16'd0, rbf_pkg::ST_SHOULD_WAIT, 5'd0, 1'b1, 1'b0, 1'b0});
    script.push_back('{ROW_OP, rbf_pkg::CFG_CAPACITY, 5'd0, rbf_pkg::MODE_READ, 4'd8,
                       64'd0, 1'b0, 16'd2, rbf_pkg::ST_OK, 5'd0, 1'b0, 1'b0, 1'b0});
    // one-byte elements keep only the low byte
    script.push_back('{ROW_REG, rbf_pkg::CFG_ELEM_BYTES, 5'd1, rbf_pkg::MODE_WRITE, 4'd0,
                       64'd0, 1'b0, 16'd0, rbf_pkg::ST_OK, 5'd0, 1'b0, 1'b0, 1'b0});
    script.push_back('{ROW_CHECK, rbf_pkg::CFG_CAPACITY, 5'd0, rbf_pkg::MODE_WRITE, 4'd1,
                       64'h1234, 1'b1, 16'd0, rbf_pkg::ST_OK, 5'd1, 1'b1, 1'b0, 1'b0});
    script.push_back('{ROW_OP, rbf_pkg::CFG_CAPACITY, 5'd0, rbf_pkg::MODE_READ, 4'd1,
                       64'd0, 1'b0, 16'd1, rbf_pkg::ST_OK, 5'd0, 1'b0, 1'b0, 1'b0});
    close_from = script.size();
    // peer closes mid-batch: the batch goes on as judged at its start
    script.push_back('{ROW_REG, rbf_pkg::CFG_CAPACITY, 5'd4, rbf_pkg::MODE_WRITE, 4'd0,
                       64'd0, 1'b0, 16'd0, rbf_pkg::ST_OK, 5'd0, 1'b0, 1'b0, 1'b0});
    script.push_back('{ROW_REG, rbf_pkg::CFG_ELEM_BYTES, 5'd8, rbf_pkg::MODE_WRITE, 4'd0,
                       64'd0, 1'b0, 16'd0, rbf_pkg::ST_OK, 5'd0, 1'b0, 1'b0, 1'b0});
    script.push_back('{ROW_OP, rbf_pkg::CFG_CAPACITY, 5'd0, rbf_pkg::MODE_WRITE, 4'd8,
                       64'hFEDC_BA98_7654_3210, 1'b0, 16'd0,
                       rbf_pkg::ST_OK, 5'd0, 1'b0, 1'b0, 1'b0});
    script.push_back('{ROW_CHECK, rbf_pkg::CFG_CAPACITY, 5'd0, rbf_pkg::MODE_CLOSE, 4'd0,
                       64'd0, 1'b0, 16'd0, rbf_pkg::ST_OK, 5'd0, 1'b1, 1'b0, 1'b1});
    script.push_back('{ROW_OP, rbf_pkg::CFG_CAPACITY, 5'd0, rbf_pkg::MODE_WRITE, 4'd3,
                       64'h0000_1111_2222_3333, 1'b0, 16'd0,
                       rbf_pkg::ST_OK, 5'd0, 1'b0, 1'b0, 1'b0});
    script.push_back('{ROW_CHECK, rbf_pkg::CFG_CAPACITY, 5'd0, rbf_pkg::MODE_WRITE, 4'd8,
                       64'h4444_5555_6666_7777, 1'b1, 16'd0,
                       rbf_pkg::ST_OK, 5'd3, 1'b1, 1'b0, 1'b1});
    script.push_back('{ROW_CHECK, rbf_pkg::CFG_CAPACITY, 5'd0, rbf_pkg::MODE_WRITE, 4'd8,
                       64'd0, 1'b1, 16'd0, rbf_pkg::ST_PEER_CLOSED, 5'd0, 1'b1, 1'b0, 1'b1});
    script.push_back('{ROW_OP, rbf_pkg::CFG_CAPACITY, 5'd0, rbf_pkg::MODE_READ, 4'd8,
                       64'd0, 1'b0, 16'd5, rbf_pkg::ST_OK, 5'd0, 1'b0, 1'b0, 1'b0});
    script.push_back('{ROW_CHECK, rbf_pkg::CFG_CAPACITY, 5'd0, rbf_pkg::MODE_READ, 4'd8,
                       64'd0, 1'b0, 16'd1, rbf_pkg::ST_PEER_CLOSED, 5'd0, 1'b0, 1'b0, 1'b1});

    // predictor matches the block's reset state
    for (int i = 0; i < SLOTS; i++) ring_mem[i] = '0;
    clear_ring();
    writer_closed = 1'b0;
    capacity_q    = rbf_pkg::CAP_RESET;
    elem_bytes_q  = rbf_pkg::EB_RESET;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_script(0, close_from);

    // random traffic over several sizes and idle mixes
    run_phase(5'd16, 5'd8, 0, 0, 1'b0, 16);
    run_phase(5'd1, 5'd1, 58, 0, 1'b0, 16);
    run_phase(5'd5, 5'd3, 0, 58, 1'b1, 16);
    run_phase(5'd9, 5'd6, 28, 28, 1'b0, 16);

    // closing part, then some traffic against a closed peer
    send_gap_pct = 0;
    stall_pct    = 0;
    run_script(close_from, script.size());
    send_gap_pct = 28;
    stall_pct    = 28;
    random_traffic(10, 1'b1);

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
